/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int TAG_W       = 24;
   localparam int PRIO_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int ENTRY_W     = TAG_W + PRIO_W;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic capture;
      logic drop_full;
      logic deq_empty;
      logic enq_empty;
      logic enq_start;
      logic shift;
      logic place;
      logic deq;
      logic load_front;
   } spq_cmd_type;

   typedef struct packed {
      logic is_enq;
      logic full;
      logic empty;
      logic one_left;
      logic gt;
      logic last;
   } spq_stat_type;

endpackage

/* rtl/core/spq_if.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [TAG_W-1:0]         tag;
   logic signed [PRIO_W-1:0] priority_req;

   modport source (output valid, output op, output tag, output priority_req, input ready);
   modport sink   (input valid, input op, input tag, input priority_req, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [TAG_W-1:0]       out_tag;
   logic [COUNT_OUT_W-1:0] count;
   logic                   is_empty;
   logic [TAG_W-1:0]       front_tag;
   logic [TAG_W-1:0]       rear_tag;

   modport source (output valid, output status, output out_tag, output count,
                   output is_empty, output front_tag, output rear_tag, input ready);
   modport sink   (input valid, input status, input out_tag, input count,
                   input is_empty, input front_tag, input rear_tag, output ready);
endinterface

/* rtl/core/spq_ram.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences one request through decode, the sorted-insert walk or the front
// reload, and the response beat.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  spq_stat_type stat,
   output spq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECIDE    = 3'd1;
   localparam logic [2:0] S_ENQ_CMP   = 3'd2;
   localparam logic [2:0] S_ENQ_PLACE = 3'd3;
   localparam logic [2:0] S_DEQ_LOAD  = 3'd4;
   localparam logic [2:0] S_RESP      = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_enq) begin
               if (stat.full) begin
                  cmd.drop_full = 1'b1;
                  state_in      = S_RESP;
               end else if (stat.empty) begin
                  cmd.enq_empty = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  cmd.enq_start = 1'b1;
                  state_in      = S_ENQ_CMP;
               end
            end else begin
               if (stat.empty) begin
                  cmd.deq_empty = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  cmd.deq  = 1'b1;
                  state_in = stat.one_left ? S_RESP : S_DEQ_LOAD;
               end
            end
         end
         S_ENQ_CMP: begin
            if (stat.gt) begin
               cmd.shift = 1'b1;
               if (stat.last) begin
                  state_in = S_ENQ_PLACE;
               end
            end else begin
               cmd.place = 1'b1;
               state_in  = S_RESP;
            end
         end
         S_ENQ_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_RESP;
         end
         S_DEQ_LOAD: begin
            cmd.load_front = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/spq_datapath.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Circular entry store in RAM with head pointer and count, a backward walk
// that shifts larger entries up by one slot, and the response registers.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_cmd_type              cmd,
   output spq_stat_type             stat,
   input  logic                     req_op,
   input  logic [TAG_W-1:0]         req_tag,
   input  logic signed [PRIO_W-1:0] req_priority_req,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [TAG_W-1:0]         rsp_out_tag,
   output logic [COUNT_OUT_W-1:0]   rsp_count,
   output logic                     rsp_is_empty,
   output logic [TAG_W-1:0]         rsp_front_tag,
   output logic [TAG_W-1:0]         rsp_rear_tag
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = IW + 1;

   function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
      return (i == IW'(CAPACITY - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
      return (i == '0) ? IW'(CAPACITY - 1) : i - 1'b1;
   endfunction

   logic                     op_ff;
   logic [TAG_W-1:0]         tag_ff;
   logic signed [PRIO_W-1:0] prio_ff;
   logic [IW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [TAG_W-1:0]         front_ff, front_in;
   logic [TAG_W-1:0]         rear_ff, rear_in;
   logic [IW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            remain_ff, remain_in;
   logic                     first_ff, first_in;
   logic                     at_front_ff, at_front_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [TAG_W-1:0]         out_tag_ff, out_tag_in;

   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   logic [ENTRY_W-1:0]       wr_data;
   logic [IW-1:0]            rd_addr;
   logic [ENTRY_W-1:0]       rd_data;
   logic [TAG_W-1:0]         rd_tag;
   logic signed [PRIO_W-1:0] rd_prio;
   logic [CW-1:0]            rear_sum;
   logic [IW-1:0]            rear_idx;
   logic [IW-1:0]            head_next;
   logic [CW+COUNT_OUT_W-1:0] count_wide;

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_tag    = rd_data[ENTRY_W-1:PRIO_W];
   assign rd_prio   = $signed(rd_data[PRIO_W-1:0]);
   assign rear_sum  = ({1'b0, head_ff} + count_ff) - CW'(1);
   assign rear_idx  = (rear_sum >= CW'(CAPACITY)) ? IW'(rear_sum - CW'(CAPACITY))
                                                  : IW'(rear_sum);
   assign head_next = idx_inc(head_ff);

   assign stat.is_enq   = (op_ff == OP_ENQ);
   assign stat.full     = (count_ff == CW'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.one_left = (count_ff == CW'(1));
   assign stat.gt       = (rd_prio > prio_ff);
   assign stat.last     = (remain_ff == CW'(1));

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      front_in    = front_ff;
      rear_in     = rear_ff;
      idx_in      = idx_ff;
      remain_in   = remain_ff;
      first_in    = first_ff;
      at_front_in = at_front_ff;
      status_in   = status_ff;
      out_tag_in  = out_tag_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_inc(idx_ff);
      wr_data     = {tag_ff, prio_ff};
      rd_addr     = idx_ff;

      if (cmd.capture) begin
         status_in  = ST_OK;
         out_tag_in = '0;
      end
      if (cmd.drop_full) begin
         status_in = ST_FULL;
      end
      if (cmd.deq_empty) begin
         status_in = ST_EMPTY;
      end
      if (cmd.enq_empty) begin
         wr_en    = 1'b1;
         wr_addr  = head_ff;
         count_in = CW'(1);
         front_in = tag_ff;
         rear_in  = tag_ff;
      end
      if (cmd.enq_start) begin
         rd_addr     = rear_idx;
         idx_in      = rear_idx;
         remain_in   = count_ff;
         first_in    = 1'b1;
         at_front_in = 1'b0;
      end
      if (cmd.shift) begin
         wr_en       = 1'b1;
         wr_data     = rd_data;
         rd_addr     = idx_dec(idx_ff);
         idx_in      = idx_dec(idx_ff);
         remain_in   = remain_ff - 1'b1;
         first_in    = 1'b0;
         at_front_in = stat.last;
      end
      if (cmd.place) begin
         wr_en    = 1'b1;
         count_in = count_ff + 1'b1;
         if (first_ff) begin
            rear_in = tag_ff;
         end
         if (at_front_ff) begin
            front_in = tag_ff;
         end
      end
      if (cmd.deq) begin
         out_tag_in = front_ff;
         head_in    = head_next;
         count_in   = count_ff - 1'b1;
         rd_addr    = head_next;
         if (stat.one_left) begin
            front_in = '0;
            rear_in  = '0;
         end
      end
      if (cmd.load_front) begin
         front_in = rd_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         tag_ff  <= req_tag;
         prio_ff <= req_priority_req;
      end
      idx_ff      <= idx_in;
      remain_ff   <= remain_in;
      first_ff    <= first_in;
      at_front_ff <= at_front_in;
      status_ff   <= status_in;
      out_tag_ff  <= out_tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         front_ff <= '0;
         rear_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

   assign count_wide    = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign rsp_status    = status_ff;
   assign rsp_out_tag   = out_tag_ff;
   assign rsp_count     = count_wide[COUNT_OUT_W-1:0];
   assign rsp_is_empty  = (count_ff == '0);
   assign rsp_front_tag = front_ff;
   assign rsp_rear_tag  = rear_ff;

endmodule

/* rtl/core/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded min-first priority queue kept in sorted order in a circular RAM.
//
//   Channel   Direction  Beat contents
//   req_bus   in         op, tag, priority_req
//   rsp_bus   out        status, out_tag, count, is_empty, front_tag, rear_tag
//
// A dequeue passes through decode and, unless it empties the queue, a front reload
// before the response beat. An enqueue that is dropped or lands in an empty queue
// goes straight from decode to the response; any other walks back from the rear,
// one entry per cycle over the single RAM port pair, shifting each larger entry.
// One request is handled at a time; a stalled response holds the unit.
// Reset empties the queue at once; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit import spq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic clock,
   input  logic reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);

   spq_cmd_type  cmd;
   spq_stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_bus.op),
      .req_tag          (req_bus.tag),
      .req_priority_req (req_bus.priority_req),
      .rsp_status       (rsp_bus.status),
      .rsp_out_tag      (rsp_bus.out_tag),
      .rsp_count        (rsp_bus.count),
      .rsp_is_empty     (rsp_bus.is_empty),
      .rsp_front_tag    (rsp_bus.front_tag),
      .rsp_rear_tag     (rsp_bus.rear_tag)
   );

endmodule

/* tb/sv/tb_sorted_priority_queue_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Sends enqueue and dequeue beats in random bursts and predicts every response
// with a behavioral copy of the queue. The stimulus walks the queue through
// empty, full and tie-heavy phases. Each response beat is compared field by
// field against the oldest prediction. The receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = 16;

   typedef struct packed {
      logic                 wait_drain;
      logic                 op;
      logic [TAG_W-1:0]     tag;
      logic [PRIO_W-1:0]    prio;
   } queue_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [TAG_W-1:0]       out_tag;
      logic [COUNT_OUT_W-1:0] count;
      logic                   is_empty;
      logic [TAG_W-1:0]       front_tag;
      logic [TAG_W-1:0]       rear_tag;
   } queue_rsp_type;

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue_unit #(.CAPACITY(QUEUE_DEPTH)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   queue_req_type pending_reqs[$];
   queue_rsp_type expected_rsps[$];

   logic [TAG_W-1:0]  model_tags[QUEUE_DEPTH];
   logic [PRIO_W-1:0] model_prios[QUEUE_DEPTH];
   int model_count = 0;

   int errors = 0;
   int reqs_sent = 0;
   int rsps_checked = 0;
   int full_drops = 0;
   int empty_deqs = 0;
   int peak_depth = 0;

   function automatic queue_rsp_type apply_queue_op(queue_req_type r);
      queue_rsp_type res;
      int pos;
      res = '0;
      if (r.op == OP_ENQ) begin
         if (model_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
            full_drops++;
         end else begin
            pos = 0;
            while (pos < model_count && $signed(model_prios[pos]) <= $signed(r.prio))
               pos++;
            for (int i = model_count; i > pos; i--) begin
               model_tags[i]  = model_tags[i-1];
               model_prios[i] = model_prios[i-1];
            end
            model_tags[pos]  = r.tag;
            model_prios[pos] = r.prio;
            model_count++;
            res.status = ST_OK;
         end
      end else begin
         if (model_count == 0) begin
            res.status = ST_EMPTY;
            empty_deqs++;
         end else begin
            res.out_tag = model_tags[0];
            for (int i = 1; i < model_count; i++) begin
               model_tags[i-1]  = model_tags[i];
               model_prios[i-1] = model_prios[i];
            end
            model_count--;
            res.status = ST_OK;
         end
      end
      if (model_count > peak_depth) peak_depth = model_count;
      res.count    = model_count[COUNT_OUT_W-1:0];
      res.is_empty = (model_count == 0);
      if (model_count != 0) begin
         res.front_tag = model_tags[0];
         res.rear_tag  = model_tags[model_count-1];
      end
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         errors++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_ENQ;
      req_bus.tag = '0;
      req_bus.priority_req = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin : drive_proc
      queue_req_type cur_item;
      logic offer;
      int burst_left;
      int gap_left;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.op <= OP_ENQ;
         req_bus.tag <= '0;
         req_bus.priority_req <= '0;
         burst_left = 8;
         gap_left = 0;
      end else begin
         offer = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            expected_rsps.push_back(apply_queue_op(cur_item));
            reqs_sent++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].wait_drain && expected_rsps.size() != 0)) begin
               cur_item = pending_reqs.pop_front();
               req_bus.op <= cur_item.op;
               req_bus.tag <= cur_item.tag;
               req_bus.priority_req <= cur_item.prio;
               offer = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
         req_bus.valid <= offer;
      end
   end

   // Receiver: checks each response beat and stalls on a pattern of its own.
   always @(posedge clock) begin : check_proc
      queue_rsp_type want;
      int mode;
      int mode_left;
      int hold_left;
      logic next_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mode = 0;
         mode_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("Response beat arrived with nothing expected");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
               check_field("out_tag", 32'(want.out_tag), 32'(rsp_bus.out_tag));
               check_field("count", 32'(want.count), 32'(rsp_bus.count));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_bus.is_empty));
               check_field("front_tag", 32'(want.front_tag), 32'(rsp_bus.front_tag));
               check_field("rear_tag", 32'(want.rear_tag), 32'(rsp_bus.rear_tag));
               rsps_checked++;
               if (rsps_checked == 250 || rsps_checked == 620) hold_left = 400;
            end
         end
         if (mode_left == 0) begin
            mode = $urandom_range(3);
            mode_left = $urandom_range(16, 80);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            case (mode)
               0: next_ready = 1'b1;
               1: next_ready = 1'($urandom_range(1));
               2: next_ready = ($urandom_range(3) == 0);
               default: next_ready = ($urandom_range(7) != 0);
            endcase
         end
         rsp_bus.ready <= next_ready;
      end
   end

   initial begin : stimulus_proc
      queue_req_type item;
      int random_items;
      int seg_len;
      int enq_pct;
      int prio_mode;
      int total_items;
      logic [PRIO_W-1:0] dir_prios[17];

      dir_prios = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'shffff,
                    16'sh0001, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh1234, 16'shedcb,
                    16'sh8000, 16'sh7fff, 16'shffff, 16'sh0001, 16'sh8000};

      // Directed beats: dequeue on empty, fill past capacity with extremes and
      // ties, then take a few entries back out.
      item = '0;
      item.op = OP_DEQ;
      item.tag = 24'hffffff;
      item.prio = 16'shffff;
      pending_reqs.push_back(item);
      for (int i = 0; i < 17; i++) begin
         item = '0;
         item.op = OP_ENQ;
         item.tag = TAG_W'((i == 0) ? 24'h000000 : (i == 16) ? 24'hffffff : 24'h414100 + i);
         item.prio = dir_prios[i];
         pending_reqs.push_back(item);
      end
      for (int i = 0; i < 6; i++) begin
         item = '0;
         item.op = OP_DEQ;
         item.tag = TAG_W'($urandom);
         item.prio = PRIO_W'($urandom);
         pending_reqs.push_back(item);
      end

      random_items = 0;
      while (random_items < 850) begin
         seg_len = $urandom_range(20, 60);
         case ($urandom_range(3))
            0: enq_pct = 90;
            1: enq_pct = 50;
            2: enq_pct = 15;
            default: enq_pct = 65;
         endcase
         prio_mode = $urandom_range(3);
         for (int k = 0; k < seg_len; k++) begin
            item.wait_drain = (k == 0) && (random_items == 0 || $urandom_range(3) == 0);
            item.op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            item.tag = TAG_W'($urandom);
            case (prio_mode)
               0: item.prio = PRIO_W'($urandom);
               1: item.prio = PRIO_W'($urandom_range(8) - 4);
               2: begin
                  case ($urandom_range(3))
                     0: item.prio = 16'sh8000;
                     1: item.prio = 16'sh7fff;
                     2: item.prio = 16'shffff;
                     default: item.prio = 16'sh0000;
                  endcase
               end
               default: item.prio = PRIO_W'(($urandom_range(1) == 0) ? $urandom
                                                                      : $urandom_range(3));
            endcase
            pending_reqs.push_back(item);
            random_items++;
         end
      end
      total_items = pending_reqs.size();

      @(negedge reset);
      while (rsps_checked < total_items)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (expected_rsps.size() != 0 || pending_reqs.size() != 0) errors++;

      $display("Covered %0d request beats and %0d checked responses, peak depth %0d.",
               reqs_sent, rsps_checked, peak_depth);
      $display("Saw %0d enqueues dropped on a full queue and %0d dequeues on an empty one.",
               full_drops, empty_deqs);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_ram.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue_unit.sv
tb/sv/tb_sorted_priority_queue_unit.sv
